### rtl/core/vn_pkg.sv
// Shared constants and types for the vector normalize block.
package vn_pkg;

    // Lane count and element format
    localparam int VN_LANES = 4;
    localparam int ELEM_W   = 16;

    // Sum of squares and square root widths
    localparam int SUM_W = 2 * ELEM_W - 1 + $clog2(VN_LANES);
    localparam int SQ_W  = SUM_W + (SUM_W % 2);
    localparam int ROOT_W = SQ_W / 2;
    localparam int DIV_W  = ROOT_W + 1;

    // Quotient bits of the per-lane divider (Q1.14 magnitude fits 15 bits)
    localparam int Q_BITS = 15;
    localparam logic [Q_BITS-1:0] Q114_ONE = Q_BITS'(16384);

    // Per-lane sideband packed through the root pipeline
    localparam int LANE_SB_W = ELEM_W + 1;
    localparam int SIDE_W    = VN_LANES * LANE_SB_W + VN_LANES + 1;

    // Latency from accepted start to result strobe
    localparam int LANE_LAT = Q_BITS + 2;
    localparam int VN_LAT   = 1 + (ROOT_W + 1) + LANE_LAT + 1;

    // Configuration register indexes
    localparam logic [1:0] CFG_VEC_LEN = 2'd0;
    localparam logic [1:0] CFG_MIN_LEN = 2'd1;

    // Flags carried alongside the lane dividers
    typedef struct packed {
        logic                short_v;
        logic                last;
        logic [VN_LANES-1:0] mask;
    } t_tag;

endpackage

### rtl/core/vn_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
module vn_sqrt
    import vn_pkg::*;
#(
    parameter int RAD_W  = SQ_W,
    parameter int SB_W   = SIDE_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [RAD_W-1:0]     i_rad,
    input  logic [SB_W-1:0]      i_side,
    output logic                 o_vld,
    output logic [RAD_W/2-1:0]   o_root,
    output logic [SB_W-1:0]      o_side
);

    localparam int RW = RAD_W / 2;

    logic [RAD_W-1:0] r_rad  [0:RW];
    logic [RW+1:0]    r_rem  [0:RW];
    logic [RW-1:0]    r_root [0:RW];
    logic [SB_W-1:0]  r_side [0:RW];
    logic             r_vld  [0:RW];

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_rad[0]  <= i_rad;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_side[0] <= i_side;
    end

    // One root bit per stage, two radicand bits consumed
    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [RW+1:0] rem_s;
        logic [RW+1:0] trial;
        logic          ge;

        always_comb begin
            rem_s = {r_rem[k][RW-1:0], r_rad[k][RAD_W-1 -: 2]};
            trial = {r_root[k], 2'b01};
            ge    = (rem_s >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rad[k+1]  <= {r_rad[k][RAD_W-3:0], 2'b00};
            r_rem[k+1]  <= ge ? (rem_s - trial) : rem_s;
            r_root[k+1] <= {r_root[k][RW-2:0], ge};
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_vld  = r_vld[RW];
    assign o_root = r_root[RW];
    assign o_side = r_side[RW];

endmodule

### rtl/core/vn_lane.sv
// One normalize lane: pipelined divide of the element by the length.
module vn_lane
    import vn_pkg::*;
#(
    parameter int RW = ROOT_W
) (
    input  logic                     i_clk,
    input  logic [ELEM_W-1:0]        i_abs,
    input  logic                     i_neg,
    input  logic [RW-1:0]            i_len,
    output logic signed [ELEM_W-1:0] o_norm
);

    localparam int DW = RW + 1;

    // q = floor((abs * 2^15 + len) / (2 * len)); the high part seeds the remainder
    logic [DW-1:0]     r_rem [0:Q_BITS];
    logic [Q_BITS-1:0] r_q   [0:Q_BITS];
    logic [Q_BITS-1:0] r_lo  [0:Q_BITS];
    logic [DW-1:0]     r_d   [0:Q_BITS];
    logic              r_neg [0:Q_BITS];
    logic signed [ELEM_W-1:0] r_norm;

    // Seed stage
    always_ff @(posedge i_clk) begin
        r_rem[0] <= DW'(i_abs) + DW'(i_len >> Q_BITS);
        r_lo[0]  <= i_len[Q_BITS-1:0];
        r_q[0]   <= '0;
        r_d[0]   <= {i_len, 1'b0};
        r_neg[0] <= i_neg;
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < Q_BITS; k++) begin : g_div
        logic [DW:0] rem_s;
        logic        ge;

        always_comb begin
            rem_s = {r_rem[k], r_lo[k][Q_BITS-1]};
            ge    = (rem_s >= {1'b0, r_d[k]});
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? DW'(rem_s - {1'b0, r_d[k]}) : DW'(rem_s);
            r_q[k+1]   <= {r_q[k][Q_BITS-2:0], ge};
            r_lo[k+1]  <= {r_lo[k][Q_BITS-2:0], 1'b0};
            r_d[k+1]   <= r_d[k];
            r_neg[k+1] <= r_neg[k];
        end
    end

    // Clamp to one and restore the sign
    logic [Q_BITS-1:0] q_sat;
    assign q_sat = (r_q[Q_BITS] > Q114_ONE) ? Q114_ONE : r_q[Q_BITS];

    always_ff @(posedge i_clk) begin
        r_norm <= r_neg[Q_BITS] ? -$signed(ELEM_W'(q_sat)) : $signed(ELEM_W'(q_sat));
    end

    assign o_norm = r_norm;

endmodule

### rtl/core/vector_normalize.sv
// Top level of the vector normalize block.
//
// Usage: drive the four Q4.12 elements and batch_last with start high; an
// item is taken on any clock edge where start is high, since busy stays low.
// A new vector may be started every cycle.
// Each result appears for one cycle with o_valid high: four Q1.14 norms,
// o_too_short and o_last_out. The receiver cannot stall the block.
// Pipeline from the accepting edge to the result: the squaring register,
// ROOT_W + 1 stages of the pipelined square root, Q_BITS + 2 stages of the
// per-lane divider, and the merge register.
// The square root and the divider each retire one bit per stage, which sets
// the depth; throughput is one vector per clock.
// Configuration: write index 0 (vector length) or 1 (minimum length) through
// i_cfg_we / i_cfg_idx / i_cfg_data while no vector is in flight.
// Reset (i_rst_n low, synchronous) clears all in-flight strobes and sets the
// vector length to 4 and the minimum length to 0.
module vector_normalize
    import vn_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [ELEM_W-1:0] i_elem_0,
    input  logic signed [ELEM_W-1:0] i_elem_1,
    input  logic signed [ELEM_W-1:0] i_elem_2,
    input  logic signed [ELEM_W-1:0] i_elem_3,
    input  logic                     i_batch_last,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [15:0]              i_cfg_data,
    output logic                     o_valid,
    output logic signed [ELEM_W-1:0] o_norm_0,
    output logic signed [ELEM_W-1:0] o_norm_1,
    output logic signed [ELEM_W-1:0] o_norm_2,
    output logic signed [ELEM_W-1:0] o_norm_3,
    output logic                     o_too_short,
    output logic                     o_last_out
);

    localparam int L = VN_LANES;

    // Configuration registers
    logic [2:0]  r_vec_len;
    logic [15:0] r_min_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_len <= 3'd4;
            r_min_len <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VEC_LEN: r_vec_len <= i_cfg_data[2:0];
                CFG_MIN_LEN: r_min_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Fully pipelined, never busy
    assign busy = 1'b0;

    logic signed [ELEM_W-1:0] x [0:L-1];
    assign x[0] = i_elem_0;
    assign x[1] = i_elem_1;
    assign x[2] = i_elem_2;
    assign x[3] = i_elem_3;

    // Lanes in use
    logic [2:0]   used;
    logic [L-1:0] mask;
    always_comb begin
        used = (32'(r_vec_len) > L) ? 3'(L) : r_vec_len;
        for (int i = 0; i < L; i++) begin
            mask[i] = (i < int'(used));
        end
    end

    // Stage 1: magnitudes and squares per lane
    logic                r_s1_vld;
    logic                r_s1_last;
    logic [L-1:0]        r_s1_mask;
    logic [ELEM_W-1:0]   r_s1_abs [0:L-1];
    logic [L-1:0]        r_s1_neg;
    logic [2*ELEM_W-1:0] r_s1_sq  [0:L-1];

    for (genvar i = 0; i < L; i++) begin : g_sq
        logic [ELEM_W-1:0] a;
        assign a = x[i][ELEM_W-1] ? ELEM_W'(-x[i]) : ELEM_W'(x[i]);

        always_ff @(posedge i_clk) begin
            r_s1_abs[i] <= a;
            r_s1_neg[i] <= x[i][ELEM_W-1];
            r_s1_sq[i]  <= mask[i] ? (32'(a) * 32'(a)) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start;
        end
        r_s1_last <= i_batch_last;
        r_s1_mask <= mask;
    end

    // Sum of squares and sideband packing
    logic [SQ_W-1:0]   sum;
    logic [SIDE_W-1:0] side_in;
    always_comb begin
        sum = '0;
        for (int i = 0; i < L; i++) begin
            sum = sum + SQ_W'(r_s1_sq[i]);
        end
        for (int i = 0; i < L; i++) begin
            side_in[i*LANE_SB_W +: LANE_SB_W] = {r_s1_neg[i], r_s1_abs[i]};
        end
        side_in[L*LANE_SB_W +: L] = r_s1_mask;
        side_in[SIDE_W-1]         = r_s1_last;
    end

    // Length by square root
    logic              rt_vld;
    logic [ROOT_W-1:0] rt_len;
    logic [SIDE_W-1:0] rt_side;

    vn_sqrt #(
        .RAD_W (SQ_W),
        .SB_W  (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s1_vld),
        .i_rad   (sum),
        .i_side  (side_in),
        .o_vld   (rt_vld),
        .o_root  (rt_len),
        .o_side  (rt_side)
    );

    // Threshold test and tag for the lane pipeline
    t_tag tag_in;
    always_comb begin
        tag_in.short_v = (rt_len <= ROOT_W'(r_min_len));
        tag_in.last    = rt_side[SIDE_W-1];
        tag_in.mask    = rt_side[L*LANE_SB_W +: L];
    end

    // Parallel lane dividers
    logic signed [ELEM_W-1:0] lane_norm [0:L-1];
    for (genvar i = 0; i < L; i++) begin : g_lane
        vn_lane #(
            .RW (ROOT_W)
        ) u_lane (
            .i_clk  (i_clk),
            .i_abs  (rt_side[i*LANE_SB_W +: ELEM_W]),
            .i_neg  (rt_side[i*LANE_SB_W + ELEM_W]),
            .i_len  (rt_len),
            .o_norm (lane_norm[i])
        );
    end

    // Tag delay line matching the lane latency
    logic r_dl_vld [0:LANE_LAT-1];
    t_tag r_dl_tag [0:LANE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                r_dl_vld[k] <= 1'b0;
            end
        end else begin
            r_dl_vld[0] <= rt_vld;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_dl_vld[k] <= r_dl_vld[k-1];
            end
        end
        r_dl_tag[0] <= tag_in;
        for (int k = 1; k < LANE_LAT; k++) begin
            r_dl_tag[k] <= r_dl_tag[k-1];
        end
    end

    // Merge stage: gate lanes by mask and threshold
    logic                     r_valid;
    logic signed [ELEM_W-1:0] r_norm [0:L-1];
    logic                     r_short;
    logic                     r_last;
    t_tag                     tag_out;
    assign tag_out = r_dl_tag[LANE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_dl_vld[LANE_LAT-1];
        end
        for (int i = 0; i < L; i++) begin
            r_norm[i] <= (tag_out.short_v || !tag_out.mask[i]) ? '0 : lane_norm[i];
        end
        r_short <= tag_out.short_v;
        r_last  <= tag_out.last;
    end

    assign o_valid     = r_valid;
    assign o_norm_0    = r_norm[0];
    assign o_norm_1    = r_norm[1];
    assign o_norm_2    = r_norm[2];
    assign o_norm_3    = r_norm[3];
    assign o_too_short = r_short;
    assign o_last_out  = r_last;

endmodule

### rtl/core/vn_check.sv
// Port-level checks for the vector normalize block, bound to the top level.
module vn_check
    import vn_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_valid,
    input logic signed [ELEM_W-1:0] o_norm_0,
    input logic signed [ELEM_W-1:0] o_norm_1,
    input logic signed [ELEM_W-1:0] o_norm_2,
    input logic signed [ELEM_W-1:0] o_norm_3,
    input logic                     o_too_short
);

    localparam logic signed [ELEM_W-1:0] P_ONE = ELEM_W'(16384);
    localparam logic signed [ELEM_W-1:0] M_ONE = -ELEM_W'(16384);

    // Every accepted beat yields exactly one result after the fixed latency
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##VN_LAT o_valid)
        else $error("result missing after accepted beat");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, VN_LAT))
        else $error("result without matching beat");

    // Too-short results carry only zeros
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_too_short) |->
            (o_norm_0 == 0 && o_norm_1 == 0 && o_norm_2 == 0 && o_norm_3 == 0))
        else $error("too_short result with nonzero norm");

    // Norms stay within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_norm_0 <= P_ONE && o_norm_0 >= M_ONE &&
                     o_norm_1 <= P_ONE && o_norm_1 >= M_ONE &&
                     o_norm_2 <= P_ONE && o_norm_2 >= M_ONE &&
                     o_norm_3 <= P_ONE && o_norm_3 >= M_ONE))
        else $error("norm out of range");

endmodule

bind vector_normalize vn_check u_vn_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_norm_0    (o_norm_0),
    .o_norm_1    (o_norm_1),
    .o_norm_2    (o_norm_2),
    .o_norm_3    (o_norm_3),
    .o_too_short (o_too_short)
);
